// ===== src/sep_pkg.sv =====
// Package for the segment endpoint push unit: pipeline record, constants, register indexes, saturation function.
package sep_pkg;

	localparam int NUM_STAGES = 75;
	localparam int SQRT_BITS = 35;
	localparam int QUO_BITS = 31;
	localparam logic [69:0] NEGLIGIBLE_SQ = 70'd43;
	localparam logic [52:0] TAN_GAIN = 53'd3;

	typedef enum logic [1:0] {
		REG_PUSH_START_ENABLE = 2'd0,
		REG_PUSH_END_ENABLE   = 2'd1,
		REG_RELATIVE_START    = 2'd2,
		REG_RELATIVE_END      = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic             is_end;
		logic             en;
		logic             rel;
		logic             tiny;
		logic [2:0][31:0] pos;
		logic [2:0][31:0] tan;
		logic [31:0]      amt;
		logic [2:0][32:0] dif;
		logic [2:0][65:0] tsq;
		logic [2:0][65:0] gsq;
		logic [69:0]      trem;
		logic [69:0]      grem;
		logic [34:0]      troot;
		logic [34:0]      groot;
		logic [66:0]      mprod;
		logic [2:0][61:0] num;
		logic [2:0][35:0] drem;
		logic [2:0][30:0] quo;
		logic [50:0]      pdist;
		logic [52:0]      tlen;
		logic [2:0][56:0] pdlo;
		logic [2:0][56:0] pdhi;
		logic [2:0][56:0] ptlo;
		logic [2:0][56:0] pthi;
		logic [2:0][53:0] shf;
		logic [2:0][53:0] stn;
		logic [2:0][31:0] npos;
		logic [2:0][31:0] ntan;
		logic             clip;
	} pipe_t;

	function automatic logic [32:0] sat32(input logic [55:0] x);
		logic [32:0] r;
		if (x[55:31] == {25{1'b0}} || x[55:31] == {25{1'b1}}) begin
			r = {1'b0, x[31:0]};
		end else if (x[55]) begin
			r = {1'b1, 32'h8000_0000};
		end else begin
			r = {1'b1, 32'h7fff_ffff};
		end
		return r;
	endfunction

endpackage

// ===== src/segment_endpoint_push_unit.sv =====
// Segment endpoint push unit: moves a curve endpoint along its tangent, fully pipelined.
// Pipeline: 35-stage square roots, 31-stage dividers.
// Throughput: one beat per cycle; the whole pipeline holds while the output beat is stalled.
// Reset: arst_n clears all stage valid bits and the four config registers to 0.
module segment_endpoint_push_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic        cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        func,
	input  logic [31:0] pos_x,
	input  logic [31:0] pos_y,
	input  logic [31:0] pos_z,
	input  logic [31:0] tan_x,
	input  logic [31:0] tan_y,
	input  logic [31:0] tan_z,
	input  logic [31:0] far_x,
	input  logic [31:0] far_y,
	input  logic [31:0] far_z,
	input  logic [31:0] push_amount,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] new_pos_x,
	output logic [31:0] new_pos_y,
	output logic [31:0] new_pos_z,
	output logic [31:0] new_tan_x,
	output logic [31:0] new_tan_y,
	output logic [31:0] new_tan_z,
	output logic        clipped
);
	import sep_pkg::*;

	logic push_start_enable_q, push_end_enable_q, relative_start_q, relative_end_q;
	pipe_t pipe_s [1:NUM_STAGES];
	logic  vld_s  [1:NUM_STAGES];
	pipe_t nxt    [1:NUM_STAGES];
	pipe_t in0;
	logic  adv;

	function automatic pipe_t step(input pipe_t p, input int k);
		pipe_t       o;
		logic [69:0] trial;
		logic [35:0] r;
		logic [66:0] m;
		logic [51:0] v1, v2;
		logic [52:0] tm;
		logic [82:0] sd, st;
		logic [55:0] np;
		logic [32:0] sp, sn;
		logic [31:0] magt;
		logic [32:0] magd;
		int          b;
		o = p;
		if (k == 2) begin
			for (int i = 0; i < 3; i++) begin
				magt = p.tan[i][31] ? 32'(-p.tan[i]) : p.tan[i];
				magd = p.dif[i][32] ? 33'(-p.dif[i]) : p.dif[i];
				o.tsq[i] = 66'(magt) * 66'(magt);
				o.gsq[i] = 66'(magd) * 66'(magd);
			end
		end else if (k == 3) begin
			o.trem = 70'(p.tsq[0]) + 70'(p.tsq[1]) + 70'(p.tsq[2]);
			o.grem = 70'(p.gsq[0]) + 70'(p.gsq[1]) + 70'(p.gsq[2]);
			o.tiny = (o.trem < NEGLIGIBLE_SQ);
			o.troot = '0;
			o.groot = '0;
		end else if (k >= 4 && k <= 3 + SQRT_BITS) begin
			b = 3 + SQRT_BITS - k;
			trial = (70'(p.troot) << (b + 1)) + (70'(1) << (2 * b));
			if (p.trem >= trial) begin
				o.trem = p.trem - trial;
				o.troot[b] = 1'b1;
			end
			trial = (70'(p.groot) << (b + 1)) + (70'(1) << (2 * b));
			if (p.grem >= trial) begin
				o.grem = p.grem - trial;
				o.groot[b] = 1'b1;
			end
		end else if (k == 4 + SQRT_BITS) begin
			if (p.trem > 70'(p.troot)) o.troot = p.troot + 35'd1;
			if (p.grem > 70'(p.groot)) o.groot = p.groot + 35'd1;
		end else if (k == 5 + SQRT_BITS) begin
			for (int i = 0; i < 3; i++) begin
				magt = p.tan[i][31] ? 32'(-p.tan[i]) : p.tan[i];
				o.num[i] = (62'(magt) << 30) + 62'(p.troot >> 1);
				o.drem[i] = 36'(o.num[i][61:31]);
				o.quo[i] = '0;
			end
			magt = p.amt[31] ? 32'(-p.amt) : p.amt;
			o.mprod = 67'(p.groot) * 67'(magt);
		end else if (k >= 6 + SQRT_BITS && k <= 5 + SQRT_BITS + QUO_BITS) begin
			b = 5 + SQRT_BITS + QUO_BITS - k;
			for (int i = 0; i < 3; i++) begin
				r = {p.drem[i][34:0], p.num[i][b]};
				if (r >= 36'(p.troot)) begin
					o.drem[i] = r - 36'(p.troot);
					o.quo[i][b] = 1'b1;
				end else begin
					o.drem[i] = r;
				end
			end
			if (k == 6 + SQRT_BITS) begin
				m = (p.mprod + 67'h8000) >> 16;
				if (p.rel) o.pdist = p.amt[31] ? 51'(-m) : 51'(m);
				else o.pdist = {{19{p.amt[31]}}, p.amt};
			end
			if (k == 7 + SQRT_BITS) begin
				o.tlen = 53'(p.troot) + TAN_GAIN * {{2{p.pdist[50]}}, p.pdist};
			end
		end else if (k == 6 + SQRT_BITS + QUO_BITS) begin
			if (p.tiny) o.quo = '0;
		end else if (k == 7 + SQRT_BITS + QUO_BITS) begin
			v1 = p.pdist[50] ? 52'(51'(-p.pdist)) : 52'(p.pdist);
			tm = p.tlen[52] ? 53'(-p.tlen) : p.tlen;
			v2 = tm[51:0];
			for (int i = 0; i < 3; i++) begin
				o.pdlo[i] = 57'(p.quo[i]) * 57'(v1[25:0]);
				o.pdhi[i] = 57'(p.quo[i]) * 57'(v1[51:26]);
				o.ptlo[i] = 57'(p.quo[i]) * 57'(v2[25:0]);
				o.pthi[i] = 57'(p.quo[i]) * 57'(v2[51:26]);
			end
		end else if (k == 8 + SQRT_BITS + QUO_BITS) begin
			for (int i = 0; i < 3; i++) begin
				sd = 83'(p.pdlo[i]) + (83'(p.pdhi[i]) << 26) + (83'(1) << 29);
				st = 83'(p.ptlo[i]) + (83'(p.pthi[i]) << 26) + (83'(1) << 29);
				o.shf[i] = (p.tan[i][31] ^ p.pdist[50]) ? 54'(-{1'b0, sd[82:30]})
					: {1'b0, sd[82:30]};
				o.stn[i] = (p.tan[i][31] ^ p.tlen[52]) ? 54'(-{1'b0, st[82:30]})
					: {1'b0, st[82:30]};
			end
		end else if (k == 9 + SQRT_BITS + QUO_BITS) begin
			o.clip = 1'b0;
			for (int i = 0; i < 3; i++) begin
				if (p.is_end) begin
					np = {{24{p.pos[i][31]}}, p.pos[i]} + {{2{p.shf[i][53]}}, p.shf[i]};
				end else begin
					np = {{24{p.pos[i][31]}}, p.pos[i]} - {{2{p.shf[i][53]}}, p.shf[i]};
				end
				sp = sat32(np);
				sn = sat32({{2{p.stn[i][53]}}, p.stn[i]});
				if (p.en) begin
					o.npos[i] = sp[31:0];
					o.ntan[i] = sn[31:0];
					o.clip = o.clip | sp[32] | sn[32];
				end else begin
					o.npos[i] = p.pos[i];
					o.ntan[i] = p.tan[i];
				end
			end
		end
		return o;
	endfunction

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push_start_enable_q <= 1'b0;
			push_end_enable_q <= 1'b0;
			relative_start_q <= 1'b0;
			relative_end_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PUSH_START_ENABLE: push_start_enable_q <= cfg_data;
				REG_PUSH_END_ENABLE:   push_end_enable_q <= cfg_data;
				REG_RELATIVE_START:    relative_start_q <= cfg_data;
				REG_RELATIVE_END:      relative_end_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign adv = !(vld_s[NUM_STAGES] && out_stall);
	assign in_stall = !adv;

	always_comb begin
		in0 = '0;
		in0.is_end = func;
		in0.en = func ? push_end_enable_q : push_start_enable_q;
		in0.rel = func ? relative_end_q : relative_start_q;
		in0.pos = {pos_z, pos_y, pos_x};
		in0.tan = {tan_z, tan_y, tan_x};
		in0.amt = push_amount;
		in0.dif[0] = {far_x[31], far_x} - {pos_x[31], pos_x};
		in0.dif[1] = {far_y[31], far_y} - {pos_y[31], pos_y};
		in0.dif[2] = {far_z[31], far_z} - {pos_z[31], pos_z};
	end

	assign nxt[1] = in0;
	for (genvar g = 2; g <= NUM_STAGES; g++) begin : g_stage
		assign nxt[g] = step(pipe_s[g-1], g);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= NUM_STAGES; i++) vld_s[i] <= 1'b0;
		end else if (adv) begin
			vld_s[1] <= in_valid;
			for (int i = 2; i <= NUM_STAGES; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 1; i <= NUM_STAGES; i++) pipe_s[i] <= nxt[i];
		end
	end

	assign out_valid = vld_s[NUM_STAGES];
	assign new_pos_x = pipe_s[NUM_STAGES].npos[0];
	assign new_pos_y = pipe_s[NUM_STAGES].npos[1];
	assign new_pos_z = pipe_s[NUM_STAGES].npos[2];
	assign new_tan_x = pipe_s[NUM_STAGES].ntan[0];
	assign new_tan_y = pipe_s[NUM_STAGES].ntan[1];
	assign new_tan_z = pipe_s[NUM_STAGES].ntan[2];
	assign clipped = pipe_s[NUM_STAGES].clip;

endmodule
